>>> design/hcsp_pkg.sv
package hcsp_pkg;

   // Opaque mid gray: 0.5 of full scale is byte code 128 for each color.
   localparam logic [31:0] FALLBACK_RESET = 32'hFF80_8080;

   localparam logic [7:0]  HASH_CHAR = 8'h23;
   localparam logic [3:0]  COUNT_CAP = 4'd9;

   // Digit counts that name a legal body format
   localparam logic [3:0]  FMT_RGB      = 4'd3;
   localparam logic [3:0]  FMT_RGBA     = 4'd4;
   localparam logic [3:0]  FMT_RRGGBB   = 4'd6;
   localparam logic [3:0]  FMT_AARRGGBB = 4'd8;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic       color_valid;
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // Scan state after the current character, handed to the formatter
   typedef struct packed {
      logic [31:0] nibbles;
      logic [3:0]  count;
      logic        error;
   } scan_type;

endpackage

>>> design/hcsp_scan.sv
module hcsp_scan
   import hcsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     take,      // an item is accepted this cycle
   input  req_type  req,
   output scan_type scan_next  // state including this character
);

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_BODY,
      PH_TRAIL
   } phase_type;

   phase_type phase_ff, phase_in;
   scan_type  scan_ff;
   phase_type phase_nx;

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // bit 4 set means not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      hex_value = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         hex_value = d[4:0];
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
         hex_value = d[4:0];
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
         hex_value = d[4:0];
      end
   endfunction

   logic [4:0] hv;
   logic       is_hex;
   logic       blank;
   scan_type   with_digit;

   always_comb begin
      hv      = hex_value(req.char_code);
      is_hex  = !hv[4];
      blank   = is_blank(req.char_code);

      with_digit.nibbles = {scan_ff.nibbles[27:0], hv[3:0]};
      with_digit.count   = (scan_ff.count < COUNT_CAP) ? scan_ff.count + 4'd1 : scan_ff.count;
      with_digit.error   = scan_ff.error;

      scan_next = scan_ff;
      phase_nx  = phase_ff;
      unique case (phase_ff)
         PH_LEAD: begin
            if (blank) begin
               phase_nx = PH_LEAD;
            end else if (req.char_code == HASH_CHAR) begin
               phase_nx = PH_BODY;
            end else if (is_hex) begin
               phase_nx  = PH_BODY;
               scan_next = with_digit;
            end else begin
               scan_next.error = 1'b1;
            end
         end
         PH_BODY: begin
            if (is_hex) begin
               scan_next = with_digit;
            end else if (blank) begin
               phase_nx = PH_TRAIL;
            end else begin
               scan_next.error = 1'b1;
            end
         end
         default: begin
            // trailing whitespace; the unused code behaves the same
            if (!blank) begin
               scan_next.error = 1'b1;
            end
         end
      endcase

      // the last character closes the string and rearms the scanner
      phase_in = req.last_char ? PH_LEAD : phase_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         scan_ff  <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         scan_ff  <= req.last_char ? scan_type'('0) : scan_next;
      end
   end

endmodule

>>> design/hcsp_format.sv
module hcsp_format
   import hcsp_pkg::*;
(
   input  scan_type    scan,
   input  logic [31:0] fallback_argb,
   output rsp_type     color
);

   function automatic logic [7:0] dup_nib(input logic [3:0] n);
      dup_nib = {n, n};
   endfunction

   logic ok;

   always_comb begin
      ok          = 1'b1;
      color.alpha = 8'hFF;
      color.red   = 8'h00;
      color.green = 8'h00;
      color.blue  = 8'h00;
      if (scan.error) begin
         ok = 1'b0;
      end else begin
         unique case (scan.count)
            FMT_RGB: begin
               color.red   = dup_nib(scan.nibbles[11:8]);
               color.green = dup_nib(scan.nibbles[7:4]);
               color.blue  = dup_nib(scan.nibbles[3:0]);
            end
            FMT_RGBA: begin
               color.red   = dup_nib(scan.nibbles[15:12]);
               color.green = dup_nib(scan.nibbles[11:8]);
               color.blue  = dup_nib(scan.nibbles[7:4]);
               color.alpha = dup_nib(scan.nibbles[3:0]);
            end
            FMT_RRGGBB: begin
               color.red   = scan.nibbles[23:16];
               color.green = scan.nibbles[15:8];
               color.blue  = scan.nibbles[7:0];
            end
            FMT_AARRGGBB: begin
               color.alpha = scan.nibbles[31:24];
               color.red   = scan.nibbles[23:16];
               color.green = scan.nibbles[15:8];
               color.blue  = scan.nibbles[7:0];
            end
            default: begin
               ok = 1'b0;
            end
         endcase
      end

      if (!ok) begin
         color.alpha = fallback_argb[31:24];
         color.red   = fallback_argb[23:16];
         color.green = fallback_argb[15:8];
         color.blue  = fallback_argb[7:0];
      end
      color.color_valid = ok;
   end

endmodule

>>> design/hex_color_string_parser.sv
// Hex color string parser. Feed a color string one character per item on the
// req_ channel, with last_char set on its final character; that item produces
// exactly one rsp_ item, all other characters produce none. Surrounding
// whitespace (space, 0x09..0x0D) and one leading '#' are allowed; the body
// must be 3, 4, 6 or 8 hex digits (RGB, RGBA, RRGGBB, AARRGGBB), short forms
// doubled per digit. Anything else returns the csr_ fallback color with
// color_valid low. Throughput is one character per clock while req_stall is
// low: the scanner updates its state in the cycle a character is taken, and
// the result register loads the decoded color on that same edge, so the result
// appears in the cycle after the last character is taken. req_stall is high only while a result sits unclaimed
// in the result register and rsp_stall holds it there; the register is freed
// and reloaded on the same edge when the result is taken.
module hex_color_string_parser
   import hcsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,

   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic        take;
   scan_type    scan_next;
   rsp_type     color;

   logic [31:0] fallback_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   // Result register can take a new item if empty or draining this cycle
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   hcsp_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req       (req_data),
      .scan_next (scan_next)
   );

   hcsp_format u_format (
      .scan          (scan_next),
      .fallback_argb (fallback_ff),
      .color         (color)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (take && req_data.last_char) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Fallback color register
   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_ff <= FALLBACK_RESET;
      end else if (csr_wr_en) begin
         fallback_ff <= csr_wr_data;
      end
   end

   // Result register; payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_data.last_char) begin
         rsp_data_ff <= color;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> bench/hex_color_string_parser_tb.sv
`timescale 1ns / 1ps

module hex_color_string_parser_tb;
   import hcsp_pkg::*;

   // Cycles without any handshake before the run is declared hung. The worst
   // legal gap is a sender burst plus a receiver burst, well under this.
   localparam int STALL_LIMIT  = 500;
   // Characters per random phase; six phases give roughly 1450 items.
   localparam int PHASE_CHARS  = 235;
   localparam int PHASE_COUNT  = 6;
   // Settle time before a register write; result lands in the cycle after last.
   localparam int SETTLE_CYCLES = 3;

   // Typed expectations for the directed table
   localparam rsp_type GRAY_FALLBACK = {1'b0, 32'hFF80_8080};
   localparam rsp_type WHITE_RGB     = {1'b1, 32'hFFFF_FFFF};
   localparam rsp_type CLEAR_ARGB    = {1'b1, 32'h0000_0000};

   typedef enum logic [1:0] {
      SCAN_LEAD,
      SCAN_BODY,
      SCAN_TRAIL
   } scan_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // Parser shadow state
   scan_state_type scan_state = SCAN_LEAD;
   logic [31:0] nibble_bits = '0;
   logic [3:0]  digit_total = '0;
   logic        string_bad = 1'b0;
   logic [31:0] fallback_color = FALLBACK_RESET;

   rsp_type     expected_colors[$];
   rsp_type     oldest_color;
   logic [7:0]  text_bytes[$];
   int          mismatches = 0;
   int          stall_left = 0;
   int          idle_cycles = 0;
   bit          quiet_run = 1'b0;

   // Directed strings; typed rows carry a hand-read result, the rest use the
   // shadow parser.
   string   dir_text  [10] = '{" ", "#", "#fFf", "a1B2", "\t0aF9c3",
                               "00000000 ", "\377", "##", "1 2", "# 9"};
   bit      dir_typed [10] = '{1, 1, 1, 0, 0, 1, 1, 1, 1, 1};
   rsp_type dir_color [10] = '{GRAY_FALLBACK, GRAY_FALLBACK, WHITE_RGB, '0, '0,
                               CLEAR_ARGB, GRAY_FALLBACK, GRAY_FALLBACK,
                               GRAY_FALLBACK, GRAY_FALLBACK};

   hex_color_string_parser DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic bit is_blank(logic [7:0] code);
      return code == 8'h20 || (code >= 8'h09 && code <= 8'h0D);
   endfunction

   // Nibble value, or bit 4 set when the code is not a hex digit
   function automatic logic [4:0] hex_nibble(logic [7:0] code);
      if (code >= "0" && code <= "9") return 5'(code - "0");
      if (code >= "a" && code <= "f") return 5'(code - "a" + 10);
      if (code >= "A" && code <= "F") return 5'(code - "A" + 10);
      return 5'h10;
   endfunction

   // Shadow parser: advances on one accepted character, returns 1 with the
   // color when the character closes a string.
   function automatic bit scan_char(input req_type item, output rsp_type color);
      logic [4:0] nib;
      logic       blank;
      logic       take;
      nib   = hex_nibble(item.char_code);
      blank = is_blank(item.char_code);
      take  = 1'b0;
      color = '0;
      case (scan_state)
         SCAN_LEAD: begin
            if (blank) begin
               take = 1'b0;
            end else if (item.char_code == HASH_CHAR) begin
               scan_state = SCAN_BODY;
            end else if (!nib[4]) begin
               scan_state = SCAN_BODY;
               take = 1'b1;
            end else begin
               string_bad = 1'b1;
            end
         end
         SCAN_BODY: begin
            if (!nib[4]) take = 1'b1;
            else if (blank) scan_state = SCAN_TRAIL;
            else string_bad = 1'b1;
         end
         default: begin
            // trailing blanks only; anything else spoils the string
            if (!blank) string_bad = 1'b1;
         end
      endcase
      if (take) begin
         nibble_bits = {nibble_bits[27:0], nib[3:0]};
         if (digit_total < COUNT_CAP) digit_total = digit_total + 4'd1;
      end
      if (!item.last_char) return 1'b0;

      case (digit_total)
         FMT_RGB: color = {1'b1, 8'hFF, {2{nibble_bits[11:8]}},
                           {2{nibble_bits[7:4]}}, {2{nibble_bits[3:0]}}};
         FMT_RGBA: color = {1'b1, {2{nibble_bits[3:0]}}, {2{nibble_bits[15:12]}},
                            {2{nibble_bits[11:8]}}, {2{nibble_bits[7:4]}}};
         FMT_RRGGBB: color = {1'b1, 8'hFF, nibble_bits[23:0]};
         FMT_AARRGGBB: color = {1'b1, nibble_bits};
         default: color = {1'b0, fallback_color};
      endcase
      if (string_bad) color = {1'b0, fallback_color};

      scan_state  = SCAN_LEAD;
      nibble_bits = '0;
      digit_total = '0;
      string_bad  = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] blank_char();
      int pick;
      pick = $urandom_range(0, 5);
      return (pick == 5) ? 8'h20 : 8'(8'h09 + pick);
   endfunction

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
   endfunction

   // Builds the next random string: mostly well-formed colors with random
   // digits, some with one character spoiled, some pure byte noise.
   task automatic compose_string();
      int kind;
      int digits;
      int spot;
      text_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
         repeat ($urandom_range(1, 8)) text_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) text_bytes.push_back(blank_char());
         if ($urandom_range(0, 1)) text_bytes.push_back(HASH_CHAR);
         if ($urandom_range(0, 5) != 0) begin
            case ($urandom_range(0, 3))
               0: digits = FMT_RGB;
               1: digits = FMT_RGBA;
               2: digits = FMT_RRGGBB;
               default: digits = FMT_AARRGGBB;
            endcase
         end else begin
            // odd counts, including past the saturation point
            digits = $urandom_range(0, 12);
         end
         repeat (digits) text_bytes.push_back(hex_char());
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) text_bytes.push_back(blank_char());
         if (text_bytes.size() == 0) text_bytes.push_back(blank_char());
         if (kind == 7) begin
            spot = $urandom_range(0, text_bytes.size() - 1);
            case ($urandom_range(0, 3))
               0: text_bytes[spot] = HASH_CHAR;
               1: text_bytes[spot] = blank_char();
               2: text_bytes[spot] = 8'($urandom_range(8'h80, 8'hFF));
               default: text_bytes[spot] = 8'($urandom_range(0, 255));
            endcase
         end
      end
   endtask

   // Offers one character, with an occasional idle burst first, and records
   // the color it should produce once it is taken.
   task automatic send_char(input req_type item, input bit typed, input rsp_type typed_color);
      rsp_type predicted;
      if (!quiet_run && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (scan_char(item, predicted))
         expected_colors.push_back(typed ? typed_color : predicted);
   endtask

   task automatic send_text();
      req_type item;
      for (int i = 0; i < text_bytes.size(); i++) begin
         item.char_code = text_bytes[i];
         item.last_char = (i == text_bytes.size() - 1);
         send_char(item, 1'b0, '0);
      end
   endtask

   // Sender stops and holds until every color is back; the block is then
   // idle and safe for a register write.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_fallback(input logic [31:0] argb);
      csr_wr_data <= argb;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      fallback_color = argb;
   endtask

   function automatic void check_byte(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // Result side: random stall bursts, and every taken color is checked
   // against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            $display("%0t: color expected none, got %h", $time, rsp_data);
            mismatches++;
         end else begin
            oldest_color = expected_colors.pop_front();
            if (rsp_data.color_valid !== oldest_color.color_valid) begin
               $display("%0t: color_valid expected %b, got %b", $time,
                        oldest_color.color_valid, rsp_data.color_valid);
               mismatches++;
            end
            check_byte("alpha", oldest_color.alpha, rsp_data.alpha);
            check_byte("red",   oldest_color.red,   rsp_data.red);
            check_byte("green", oldest_color.green, rsp_data.green);
            check_byte("blue",  oldest_color.blue,  rsp_data.blue);
         end
      end
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Hang detector: counts cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles < STALL_LIMIT) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         $display("hex_color_string_parser_tb: FAIL");
         $finish;
      end
   end

   initial begin
      logic [31:0] fallback_settings [PHASE_COUNT];
      req_type     item;
      int          sent;

      // Extremes, a fixed mixed pattern, the reset value and two random colors
      fallback_settings[0] = 32'h0000_0000;
      fallback_settings[1] = 32'hFFFF_FFFF;
      fallback_settings[2] = $urandom();
      fallback_settings[3] = 32'h8000_0001;
      fallback_settings[4] = $urandom();
      fallback_settings[5] = FALLBACK_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run with the fallback at its reset value
      for (int r = 0; r < 10; r++) begin
         for (int i = 0; i < dir_text[r].len(); i++) begin
            item.char_code = dir_text[r][i];
            item.last_char = (i == dir_text[r].len() - 1);
            send_char(item, dir_typed[r], dir_color[r]);
         end
      end
      drain();

      // Random phases, a new fallback color each; the last one runs flat out
      for (int p = 0; p < PHASE_COUNT; p++) begin
         program_fallback(fallback_settings[p]);
         quiet_run = (p == PHASE_COUNT - 1);
         sent = 0;
         while (sent < PHASE_CHARS) begin
            compose_string();
            send_text();
            sent += text_bytes.size();
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("hex_color_string_parser_tb: PASS");
      end else begin
         $display("hex_color_string_parser_tb: FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
design/hcsp_pkg.sv
design/hcsp_scan.sv
design/hcsp_format.sv
design/hex_color_string_parser.sv
bench/hex_color_string_parser_tb.sv
